>>> hw/rtl/gbt_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the generation barrier table.
// Depends on nothing; every other file of the block refers to it by scoped names.
package gbt_pkg;

  localparam int TABLE_DEPTH      = 256;
  localparam int MAX_PARTICIPANTS = 64;

  localparam int IDX_W  = 8;
  localparam int GEN_W  = 16;
  localparam int SND_W  = 8;
  localparam int PART_W = 16;
  localparam int MB_W   = 9;
  localparam int ALLOC_W = 9;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 1;

  localparam int CNT_W  = $clog2(MAX_PARTICIPANTS + 1);
  localparam int MASK_BIT_W = $clog2(MAX_PARTICIPANTS);

  localparam logic [MB_W-1:0]    CAP_LIMIT_RST    = MB_W'(256);
  localparam logic [PART_W-1:0]  DEFAULT_PART_RST = PART_W'(2);
  localparam logic [ALLOC_W-1:0] ALLOC_MAX        = {ALLOC_W{1'b1}};

  typedef enum logic [0:0] {
    ACT_ARRIVE = 1'b0,
    ACT_SET    = 1'b1
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAP_LIMIT    = 1'b0,
    CFG_DEFAULT_PART = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_RELEASE  = 3'd1,
    ST_LATE     = 3'd2,
    ST_FUTURE   = 3'd3,
    ST_DUP      = 3'd4,
    ST_CAPACITY = 3'd5,
    ST_INVALID  = 3'd6
  } status_t;

  typedef struct packed {
    logic [CNT_W-1:0]            part_cnt;
    logic [GEN_W-1:0]            gen;
    logic [CNT_W-1:0]            total;
    logic [MAX_PARTICIPANTS-1:0] mask;
  } entry_t;

  typedef struct packed {
    logic              action;
    logic [IDX_W-1:0]  barrier_index;
    logic [GEN_W-1:0]  generation;
    logic [SND_W-1:0]  sender;
    logic [PART_W-1:0] participants;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic              release_valid;
    logic [IDX_W-1:0]  release_index;
    logic [GEN_W-1:0]  release_generation;
    logic              exception_flag;
  } rsp_t;

  typedef struct packed {
    logic   wr_en;
    logic   create;
    entry_t ent;
  } upd_t;

  function automatic logic count_ok(input logic [PART_W-1:0] n);
    return (n >= PART_W'(2)) && (n <= PART_W'(MAX_PARTICIPANTS));
  endfunction

  function automatic entry_t fresh_entry(input logic [PART_W-1:0] n);
    entry_t e;
    e.part_cnt = n[CNT_W-1:0];
    e.gen      = '0;
    e.total    = '0;
    e.mask     = '0;
    return e;
  endfunction

endpackage

>>> hw/rtl/gbt_in_if.sv
`timescale 1ns / 1ps
// Input channel of the barrier table: valid/ready handshake with request fields.
// Uses widths from gbt_pkg.
interface gbt_in_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [gbt_pkg::IDX_W-1:0]  barrier_index;
  logic [gbt_pkg::GEN_W-1:0]  generation;
  logic [gbt_pkg::SND_W-1:0]  sender;
  logic [gbt_pkg::PART_W-1:0] participants;

  modport source (output valid, action, barrier_index, generation, sender, participants,
                  input ready);
  modport sink (input valid, action, barrier_index, generation, sender, participants,
                output ready);
endinterface

>>> hw/rtl/gbt_out_if.sv
`timescale 1ns / 1ps
// Result channel of the barrier table: valid/ready handshake with result fields.
// Uses widths from gbt_pkg.
interface gbt_out_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                status;
  logic                      release_valid;
  logic [gbt_pkg::IDX_W-1:0] release_index;
  logic [gbt_pkg::GEN_W-1:0] release_generation;
  logic                      exception_flag;

  modport source (output valid, status, release_valid, release_index, release_generation,
                  exception_flag, input ready);
  modport sink (input valid, status, release_valid, release_index, release_generation,
                exception_flag, output ready);
endinterface

>>> hw/rtl/generation_barrier_table.sv
`timescale 1ns / 1ps
// Top level of the generation barrier table: input stage, entry memory,
// result register and configuration registers. Depends on gbt_pkg, gbt_in_if,
// gbt_out_if and gbt_update.
//
// The block takes one beat per clock while the result side is ready, and returns
// exactly one result beat for each. An accepted beat is held in the decision stage
// and its result is then registered in the result register. The entry memory is
// read when a beat is accepted, and the decision and write-back happen in the
// decision stage; the most recent write is forwarded, so beats to the same barrier
// may follow each other in consecutive cycles. A stalled result holds the decision
// stage, and the input is then held off. Entry valid bits live in flip-flops and
// clear at reset, so no clearing pass is needed and the block is ready right after
// reset.
module generation_barrier_table (
  input  logic                            clk,
  input  logic                            rst_n,
  gbt_in_if.sink                          in_bus,
  gbt_out_if.source                       out_bus,
  input  logic                            cfg_we,
  input  logic [gbt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gbt_pkg::CFG_W-1:0]       cfg_wdata
);

  gbt_pkg::entry_t mem [gbt_pkg::TABLE_DEPTH];

  logic [gbt_pkg::TABLE_DEPTH-1:0] entry_valid_r;
  logic [gbt_pkg::ALLOC_W-1:0]     alloc_r;
  logic [gbt_pkg::MB_W-1:0]        cap_limit_r;
  logic [gbt_pkg::PART_W-1:0]      default_part_r;

  gbt_pkg::req_t   s1_req_r;
  logic            s1_vld_r;
  gbt_pkg::entry_t rdata_r;

  logic                      wr_vld_r;
  logic [gbt_pkg::IDX_W-1:0] wr_idx_r;
  gbt_pkg::entry_t           wr_ent_r;

  gbt_pkg::rsp_t out_r;
  logic          out_vld_r;

  logic            in_fire;
  logic            s1_fire;
  gbt_pkg::req_t   in_req;
  gbt_pkg::entry_t s1_ent;
  gbt_pkg::rsp_t   rsp;
  gbt_pkg::upd_t   upd;

  assign s1_fire = s1_vld_r && (!out_vld_r || out_bus.ready);
  assign in_bus.ready = !s1_vld_r || s1_fire;
  assign in_fire = in_bus.valid && in_bus.ready;

  assign in_req.action        = in_bus.action;
  assign in_req.barrier_index = in_bus.barrier_index;
  assign in_req.generation    = in_bus.generation;
  assign in_req.sender        = in_bus.sender;
  assign in_req.participants  = in_bus.participants;

  assign s1_ent = (wr_vld_r && (wr_idx_r == s1_req_r.barrier_index)) ? wr_ent_r : rdata_r;

  gbt_update u_update (
    .req        (s1_req_r),
    .ent_valid  (entry_valid_r[s1_req_r.barrier_index]),
    .ent        (s1_ent),
    .alloc      (alloc_r),
    .cap_limit  (cap_limit_r),
    .dflt_parts (default_part_r),
    .rsp        (rsp),
    .upd        (upd)
  );

  always_ff @(posedge clk) begin
    if (s1_fire && upd.wr_en) begin
      mem[s1_req_r.barrier_index] <= upd.ent;
    end
    if (in_fire) begin
      rdata_r <= mem[in_bus.barrier_index];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r <= in_req;
    end
    if (s1_fire) begin
      out_r <= rsp;
    end
    if (s1_fire && upd.wr_en) begin
      wr_idx_r <= s1_req_r.barrier_index;
      wr_ent_r <= upd.ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r       <= 1'b0;
      out_vld_r      <= 1'b0;
      wr_vld_r       <= 1'b0;
      entry_valid_r  <= '0;
      alloc_r        <= '0;
      cap_limit_r    <= gbt_pkg::CAP_LIMIT_RST;
      default_part_r <= gbt_pkg::DEFAULT_PART_RST;
    end else begin
      if (in_fire) begin
        s1_vld_r <= 1'b1;
      end else if (s1_fire) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_fire) begin
        out_vld_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_vld_r <= 1'b0;
      end
      if (s1_fire && upd.wr_en) begin
        wr_vld_r <= 1'b1;
      end
      if (s1_fire && upd.create) begin
        entry_valid_r[s1_req_r.barrier_index] <= 1'b1;
        if (alloc_r != gbt_pkg::ALLOC_MAX) begin
          alloc_r <= alloc_r + gbt_pkg::ALLOC_W'(1);
        end
      end
      if (cfg_we) begin
        unique case (cfg_index)
          gbt_pkg::CFG_CAP_LIMIT:    cap_limit_r    <= cfg_wdata[gbt_pkg::MB_W-1:0];
          gbt_pkg::CFG_DEFAULT_PART: default_part_r <= cfg_wdata[gbt_pkg::PART_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign out_bus.valid              = out_vld_r;
  assign out_bus.status             = out_r.status;
  assign out_bus.release_valid      = out_r.release_valid;
  assign out_bus.release_index      = out_r.release_index;
  assign out_bus.release_generation = out_r.release_generation;
  assign out_bus.exception_flag     = out_r.exception_flag;

  a_alloc_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (alloc_r >= $past(alloc_r)))
    else $error("allocated entry count decreased");

  a_write_to_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr_vld_r |-> entry_valid_r[wr_idx_r])
    else $error("forwarded write targets an entry that is not valid");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !s1_fire) |=> (s1_vld_r && $stable(s1_req_r)))
    else $error("stalled request left the decision stage");

  a_release_no_exc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.release_valid) |->
      (!out_r.exception_flag && (out_r.status == gbt_pkg::ST_RELEASE)))
    else $error("release result carries an exception or wrong status");

endmodule

>>> hw/rtl/gbt_update.sv
`timescale 1ns / 1ps
// Per-beat decision logic: classifies one request against its table entry and
// computes the result and the entry's new contents. Depends on gbt_pkg.
module gbt_update (
  input  gbt_pkg::req_t                     req,
  input  logic                              ent_valid,
  input  gbt_pkg::entry_t                   ent,
  input  logic [gbt_pkg::ALLOC_W-1:0]       alloc,
  input  logic [gbt_pkg::MB_W-1:0]          cap_limit,
  input  logic [gbt_pkg::PART_W-1:0]        dflt_parts,
  output gbt_pkg::rsp_t                     rsp,
  output gbt_pkg::upd_t                     upd
);

  gbt_pkg::entry_t             base;
  logic                        go;
  logic                        tracked;
  logic [gbt_pkg::CNT_W-1:0]   total_inc;
  logic [gbt_pkg::MASK_BIT_W-1:0] bit_sel;

  assign tracked = (req.sender < gbt_pkg::SND_W'(gbt_pkg::MAX_PARTICIPANTS));
  assign bit_sel = req.sender[gbt_pkg::MASK_BIT_W-1:0];

  always_comb begin
    rsp.status             = gbt_pkg::ST_OK;
    rsp.release_valid      = 1'b0;
    rsp.release_index      = '0;
    rsp.release_generation = '0;
    rsp.exception_flag     = 1'b0;
    upd.wr_en              = 1'b0;
    upd.create             = 1'b0;
    upd.ent                = ent;
    base                   = ent;
    go                     = 1'b0;
    total_inc              = ent.total + gbt_pkg::CNT_W'(1);

    if (req.action == gbt_pkg::ACT_SET) begin
      if (!gbt_pkg::count_ok(req.participants)) begin
        rsp.status = gbt_pkg::ST_INVALID;
      end else begin
        upd.wr_en  = 1'b1;
        upd.create = !ent_valid;
        upd.ent    = gbt_pkg::fresh_entry(req.participants);
      end
    end else begin
      if (ent_valid) begin
        go = 1'b1;
      end else if (alloc >= gbt_pkg::ALLOC_W'(cap_limit)) begin
        rsp.status         = gbt_pkg::ST_CAPACITY;
        rsp.exception_flag = 1'b1;
      end else if (!gbt_pkg::count_ok(dflt_parts)) begin
        rsp.status = gbt_pkg::ST_INVALID;
      end else begin
        go         = 1'b1;
        upd.create = 1'b1;
        upd.wr_en  = 1'b1;
        base       = gbt_pkg::fresh_entry(dflt_parts);
      end

      upd.ent   = base;
      total_inc = base.total + gbt_pkg::CNT_W'(1);

      if (go) begin
        if (req.generation < base.gen) begin
          rsp.status         = gbt_pkg::ST_LATE;
          rsp.exception_flag = 1'b1;
        end else if (req.generation > base.gen) begin
          rsp.status = gbt_pkg::ST_FUTURE;
        end else if (tracked && base.mask[bit_sel]) begin
          rsp.status = gbt_pkg::ST_DUP;
        end else begin
          upd.wr_en = 1'b1;
          if (total_inc >= base.part_cnt) begin
            rsp.status             = gbt_pkg::ST_RELEASE;
            rsp.release_valid      = 1'b1;
            rsp.release_index      = req.barrier_index;
            rsp.release_generation = base.gen;
            upd.ent.gen            = base.gen + gbt_pkg::GEN_W'(1);
            upd.ent.total          = '0;
            upd.ent.mask           = '0;
          end else begin
            upd.ent.total = total_inc;
            if (tracked) begin
              upd.ent.mask[bit_sel] = 1'b1;
            end
          end
        end
      end
    end
  end

endmodule

>>> tb/gbt_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the generation barrier table: keeps its own copy of the
// barrier entries and registers, predicts one result per request beat and compares.
// Depends on gbt_pkg, gbt_in_if and gbt_out_if.
module gbt_result_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  gbt_in_if                             in_mon,
  gbt_out_if                            out_mon,
  input  logic                          cfg_we,
  input  logic [gbt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gbt_pkg::CFG_W-1:0]     cfg_wdata,
  output int                            mismatches,
  output int                            awaiting,
  output int                            releases_seen
);
  import gbt_pkg::*;

  logic                        bar_valid [TABLE_DEPTH];
  logic [CNT_W-1:0]            bar_parts [TABLE_DEPTH];
  logic [GEN_W-1:0]            bar_gen   [TABLE_DEPTH];
  logic [CNT_W-1:0]            bar_total [TABLE_DEPTH];
  logic [MAX_PARTICIPANTS-1:0] bar_mask  [TABLE_DEPTH];
  logic [ALLOC_W-1:0]          live_entries;
  logic [MB_W-1:0]             cap_limit;
  logic [PART_W-1:0]           auto_parts;
  rsp_t                        pending_results [$];

  function automatic logic parts_usable(input logic [PART_W-1:0] n);
    return (int'(n) >= 2) && (int'(n) <= MAX_PARTICIPANTS);
  endfunction

  function automatic void open_entry(input int idx, input logic [PART_W-1:0] n);
    if (!bar_valid[idx]) begin
      bar_valid[idx] = 1'b1;
      if (live_entries != ALLOC_MAX) live_entries = live_entries + 1'b1;
    end
    bar_parts[idx] = n[CNT_W-1:0];
    bar_gen[idx]   = '0;
    bar_total[idx] = '0;
    bar_mask[idx]  = '0;
  endfunction

  function automatic rsp_t step_barrier(input req_t rq);
    rsp_t                  res;
    int                    idx;
    logic                  admitted;
    logic [CNT_W-1:0]      total_next;
    logic [MASK_BIT_W-1:0] bit_pos;
    logic                  tracked;
    res        = '0;
    res.status = ST_OK;
    idx        = int'(rq.barrier_index);
    bit_pos    = rq.sender[MASK_BIT_W-1:0];
    tracked    = int'(rq.sender) < MAX_PARTICIPANTS;
    if (rq.action == ACT_SET) begin
      if (idx >= TABLE_DEPTH || !parts_usable(rq.participants)) begin
        res.status = ST_INVALID;
      end else begin
        open_entry(idx, rq.participants);
      end
    end else if (idx >= TABLE_DEPTH) begin
      res.status         = ST_CAPACITY;
      res.exception_flag = 1'b1;
    end else begin
      admitted = 1'b1;
      if (!bar_valid[idx]) begin
        if (live_entries >= cap_limit) begin
          res.status         = ST_CAPACITY;
          res.exception_flag = 1'b1;
          admitted           = 1'b0;
        end else if (!parts_usable(auto_parts)) begin
          res.status = ST_INVALID;
          admitted   = 1'b0;
        end else begin
          open_entry(idx, auto_parts);
        end
      end
      if (admitted) begin
        if (rq.generation < bar_gen[idx]) begin
          res.status         = ST_LATE;
          res.exception_flag = 1'b1;
        end else if (rq.generation > bar_gen[idx]) begin
          res.status = ST_FUTURE;
        end else if (tracked && bar_mask[idx][bit_pos]) begin
          res.status = ST_DUP;
        end else begin
          if (tracked) bar_mask[idx][bit_pos] = 1'b1;
          total_next = bar_total[idx] + 1'b1;
          if (total_next >= bar_parts[idx]) begin
            res.status             = ST_RELEASE;
            res.release_valid      = 1'b1;
            res.release_index      = rq.barrier_index;
            res.release_generation = bar_gen[idx];
            bar_gen[idx]           = bar_gen[idx] + 1'b1;
            bar_total[idx]         = '0;
            bar_mask[idx]          = '0;
          end else begin
            bar_total[idx] = total_next;
          end
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    req_t rq;
    rsp_t want;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        bar_valid[i] = 1'b0;
        bar_parts[i] = '0;
        bar_gen[i]   = '0;
        bar_total[i] = '0;
        bar_mask[i]  = '0;
      end
      live_entries = '0;
      cap_limit    = CAP_LIMIT_RST;
      auto_parts   = DEFAULT_PART_RST;
      pending_results.delete();
      mismatches    = 0;
      releases_seen = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_CAP_LIMIT:    cap_limit  = cfg_wdata[MB_W-1:0];
          CFG_DEFAULT_PART: auto_parts = cfg_wdata[PART_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        rq.action        = in_mon.action;
        rq.barrier_index = in_mon.barrier_index;
        rq.generation    = in_mon.generation;
        rq.sender        = in_mon.sender;
        rq.participants  = in_mon.participants;
        want             = step_barrier(rq);
        pending_results  = {pending_results, want};
      end
      if (out_mon.valid && out_mon.ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result beat with no request outstanding: status %0d idx %0d gen %0d",
                     out_mon.status, out_mon.release_index, out_mon.release_generation);
        end else begin
          want = pending_results.pop_front();
          if (want.release_valid) releases_seen++;
          if (out_mon.status !== want.status ||
              out_mon.release_valid !== want.release_valid ||
              out_mon.release_index !== want.release_index ||
              out_mon.release_generation !== want.release_generation ||
              out_mon.exception_flag !== want.exception_flag) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: want st %0d rel %0b idx %0d gen %0d exc %0b, %s %0d %0b %0d %0d %0b",
                       want.status, want.release_valid, want.release_index,
                       want.release_generation, want.exception_flag, "got",
                       out_mon.status, out_mon.release_valid, out_mon.release_index,
                       out_mon.release_generation, out_mon.exception_flag);
          end
        end
      end
    end
    awaiting = pending_results.size();
  end

endmodule

>>> tb/tb_generation_barrier_table.sv
`timescale 1ns / 1ps
// Top of the generation barrier table testbench: clock, reset, request and
// register stimulus, result-side stalls and the verdict.
// Depends on gbt_pkg, gbt_in_if, gbt_out_if, gbt_result_checker and the block.
module tb_generation_barrier_table;
  import gbt_pkg::*;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 6;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   mismatches;
  int                   awaiting;
  int                   releases_seen;
  int                   beats_sent;
  int                   settings_used;
  int                   cycle_count = 0;
  bit                   steady;

  gbt_in_if  in_bus ();
  gbt_out_if out_bus ();

  generation_barrier_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  gbt_result_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_bus),
    .out_mon       (out_bus),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .awaiting      (awaiting),
    .releases_seen (releases_seen)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("run stopped by the cycle limit after %0d cycles", cycle_count);
      $display("tb_generation_barrier_table: done, errors");
      $finish;
    end
  end

  initial begin : result_side
    int left;
    bit rdy;
    left = 0;
    rdy  = 1'b0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (steady) begin
        rdy  = 1'b1;
        left = 0;
      end else if (left > 0) begin
        left--;
      end else begin
        rdy  = ~rdy;
        if (rdy) left = $urandom_range(0, 15);
        else if ($urandom_range(0, 4) == 0) left = $urandom_range(8, 40);
        else left = $urandom_range(0, 2);
      end
      out_bus.ready <= rdy;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  task automatic push_beat(input action_t act, input logic [IDX_W-1:0] idx,
                           input logic [GEN_W-1:0] gen, input logic [SND_W-1:0] snd,
                           input logic [PART_W-1:0] parts);
    int gap;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.action        <= act;
    in_bus.barrier_index <= idx;
    in_bus.generation    <= gen;
    in_bus.sender        <= snd;
    in_bus.participants  <= parts;
    in_bus.valid         <= 1'b1;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic arrive(input logic [IDX_W-1:0] idx, input logic [GEN_W-1:0] gen,
                        input logic [SND_W-1:0] snd);
    push_beat(ACT_ARRIVE, idx, gen, snd, PART_W'($urandom));
  endtask

  task automatic set_parts(input logic [IDX_W-1:0] idx, input logic [PART_W-1:0] n);
    push_beat(ACT_SET, idx, GEN_W'($urandom), SND_W'($urandom), n);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic configure(input logic [CFG_W-1:0] cap, input logic [CFG_W-1:0] dflt);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CAP_LIMIT;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_index <= CFG_DEFAULT_PART;
    cfg_wdata <= dflt;
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic run_round(input logic [IDX_W-1:0] idx, input int n, input int gens);
    logic [MAX_PARTICIPANTS-1:0] seen;
    int done;
    int pick;
    int s;
    int ahead;
    set_parts(idx, PART_W'(n));
    for (int g = 0; g < gens; g++) begin
      seen = '0;
      done = 0;
      while (done < n) begin
        pick = $urandom_range(0, 99);
        if (pick < 7 && g > 0) begin
          arrive(idx, GEN_W'($urandom_range(0, g - 1)), SND_W'($urandom));
        end else if (pick < 13) begin
          ahead = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 60000);
          arrive(idx, GEN_W'(g + ahead), SND_W'($urandom));
        end else if (pick < 19 && seen != '0) begin
          do s = $urandom_range(0, 63); while (!seen[s]);
          arrive(idx, GEN_W'(g), SND_W'(s));
        end else begin
          if (pick < 40) begin
            s = $urandom_range(64, 255);
          end else begin
            do s = $urandom_range(0, 63); while (seen[s]);
            seen[s] = 1'b1;
          end
          arrive(idx, GEN_W'(g), SND_W'(s));
          done++;
        end
      end
    end
  endtask

  task automatic noise_beat();
    logic [IDX_W-1:0] idx;
    idx = ($urandom_range(0, 1) == 0) ? IDX_W'($urandom_range(0, 15)) : IDX_W'($urandom);
    if ($urandom_range(0, 99) < 30)
      set_parts(idx, ($urandom_range(0, 1) == 0) ? PART_W'($urandom_range(2, 64))
                                                 : PART_W'($urandom));
    else
      arrive(idx, ($urandom_range(0, 1) == 0) ? GEN_W'($urandom_range(0, 3)) : GEN_W'($urandom),
             SND_W'($urandom));
  endtask

  initial begin : stimulus
    int target;
    int n_pick;
    int n;
    logic [IDX_W-1:0] idx;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_wdata            = '0;
    in_bus.valid         = 1'b0;
    in_bus.action        = 1'b0;
    in_bus.barrier_index = '0;
    in_bus.generation    = '0;
    in_bus.sender        = '0;
    in_bus.participants  = '0;
    steady               = 1'b0;
    beats_sent           = 0;
    settings_used        = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    arrive(8'd0, 16'd0, 8'd0);
    arrive(8'd0, 16'd0, 8'd0);
    arrive(8'd0, 16'd0, 8'd255);
    arrive(8'd0, 16'd0, 8'd1);
    arrive(8'd0, 16'hFFFF, 8'd1);
    set_parts(8'd1, 16'd0);
    set_parts(8'd1, 16'd1);
    set_parts(8'd1, 16'd65);
    set_parts(8'd1, 16'hFFFF);
    set_parts(8'd255, 16'd64);
    set_parts(8'd1, 16'd2);
    arrive(8'd1, 16'd0, 8'd63);
    arrive(8'd1, 16'd0, 8'd64);
    arrive(8'd1, 16'd1, 8'd64);
    arrive(8'd1, 16'd1, 8'd64);
    configure(16'd3, 16'd2);
    arrive(8'd2, 16'd0, 8'd0);
    configure(16'hFE00, 16'd0);
    arrive(8'd3, 16'd0, 8'd0);
    set_parts(8'd3, 16'd2);
    configure(16'hFFFF, 16'd1);
    arrive(8'd4, 16'd0, 8'd0);
    configure(16'hFFFF, 16'hFFFF);
    arrive(8'd5, 16'd0, 8'd0);
    configure(16'hFFFF, 16'd64);
    arrive(8'd6, 16'd0, 8'd0);
    arrive(8'd6, 16'd0, 8'd0);
    set_parts(8'd0, 16'd3);
    arrive(8'd0, 16'd0, 8'd7);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: configure(16'd256, 16'd2);
        1: configure(16'hFE00, 16'd64);
        2: configure(16'hFFFF, ($urandom_range(0, 1) == 0) ? CFG_W'($urandom_range(0, 1))
                                                             : CFG_W'($urandom_range(65, 65535)));
        3: configure(CFG_W'($urandom_range(0, 300)), CFG_W'($urandom_range(2, 64)));
        default: configure(CFG_W'($urandom_range(1, 40)), CFG_W'($urandom_range(2, 5)));
      endcase
      target = beats_sent + 240;
      while (beats_sent < target) begin
        steady = ($urandom_range(0, 9) < 2);
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 6)) noise_beat();
        end else begin
          idx = ($urandom_range(0, 9) < 6) ? IDX_W'($urandom_range(0, 15)) : IDX_W'($urandom);
          n_pick = $urandom_range(0, 9);
          if (n_pick < 7) n = $urandom_range(2, 6);
          else if (n_pick < 9) n = $urandom_range(7, 20);
          else n = $urandom_range(21, 64);
          run_round(idx, n, $urandom_range(1, 3));
        end
      end
      steady = 1'b0;
    end

    drain();
    $display("covered %0d request beats under %0d register settings with %0d releases",
             beats_sent, settings_used, releases_seen);
    if (mismatches == 0 && awaiting == 0) begin
      $display("tb_generation_barrier_table: done, clean");
    end else begin
      $display("tb_generation_barrier_table: done, errors");
    end
    $finish;
  end

endmodule
